// ===== rtl/vfcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfcm_pkg
// widths, codes and defaults shared by the voxel face culling mesher
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // default geometry
    localparam int LINE_DEF     = 16;
    localparam int HEIGHT_DEF   = 128;
    localparam int SECTIONS_DEF = 4;

    // field widths
    localparam int OP_W       = 2;
    localparam int POS_XY_W   = 4;
    localparam int POS_Z_W    = 7;
    localparam int TYPE_W     = 3;
    localparam int FACE_W     = 3;
    localparam int SECTION_W  = 2;
    localparam int CNT_W      = 20;
    localparam int CXY_W      = 14;
    localparam int CZ_W       = 17;
    localparam int VSIZE_W    = 11;
    localparam int NUM_FACES  = 6;

    // packed beat widths, rounded up to whole bytes
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 72;

    // configuration reset value
    localparam logic [VSIZE_W-1:0] VSIZE_RESET = 11'd100;

    // counter advance per emitted face
    localparam logic [CNT_W-1:0] CNT_STEP = 20'd4;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_MESH  = 2'd2;

    // face direction codes, also the bit order of the visibility mask
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
    localparam logic [FACE_W-1:0] FACE_MZ = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_MY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PX = 3'd4;
    localparam logic [FACE_W-1:0] FACE_MX = 3'd5;

endpackage

// ===== rtl/voxel_face_culling_mesher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// voxel chunk store with visible face extraction per meshed voxel
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one command beat; s_tuser carries the operation (write type,
//   start mesh pass, mesh voxel), s_tdata the voxel position and type
//   m_ channel: one beat per visible face of a meshed voxel, in the order
//   +z, -z, +y, -y, +x, -x; m_tlast marks the final face of the voxel
//   cfg_wen / cfg_wdata: writes voxel_size; use only while the block is idle, unchecked
// sequencing
//   write and start leave the block idle, so s_tready stays high
//   an in-chunk mesh beat keeps s_tready low while its own cell and six
//   neighbours are read through the single voxel memory port (registered
//   read), then while its visible faces are emitted, pausing on back pressure
// reset
//   the voxel memory is swept to empty, one entry per cycle, over all
//   LINE*LINE*HEIGHT entries (32768 at default size); s_tready stays low
//   meanwhile, cfg writes are still taken; section counters clear at once
// back pressure
//   the face output register holds its beat while m_tready is low and face
//   emission pauses; the next command beat is taken as soon as the last
//   face of the previous voxel sits in the output register
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher #(
    parameter int LINE     = vfcm_pkg::LINE_DEF,
    parameter int HEIGHT   = vfcm_pkg::HEIGHT_DEF,
    parameter int SECTIONS = vfcm_pkg::SECTIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wen,
    input  logic [vfcm_pkg::VSIZE_W-1:0]  cfg_wdata,   // voxel_size
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vfcm_pkg::S_TDATA_W-1:0] s_tdata,    // pos_x, pos_y, pos_z, voxel_type
    input  logic [vfcm_pkg::OP_W-1:0]     s_tuser,     // operation
    // face stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vfcm_pkg::M_TDATA_W-1:0] m_tdata,    // section, first_vertex,
                                                       // center_x, center_y, center_z
    output logic [vfcm_pkg::FACE_W-1:0]   m_tuser,     // face_dir
    output logic                          m_tlast      // last_face
);
    import vfcm_pkg::*;

    localparam int DEPTH  = LINE * LINE * HEIGHT;
    localparam int LL     = LINE * LINE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int PXY_W  = POS_XY_W + VSIZE_W;
    localparam int PZ_W   = POS_Z_W + VSIZE_W;
    localparam int PAD_W  = M_TDATA_W - (SECTION_W + CNT_W + 2 * CXY_W + CZ_W);
    localparam int SPAD_W = S_TDATA_W - (2 * POS_XY_W + POS_Z_W + TYPE_W);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // read step bounds: step 0 own cell, steps 1..6 neighbours, step 7 drains
    localparam logic [2:0] STEP_LAST = 3'd7;

    // ------------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------------
    logic [POS_XY_W-1:0] in_x, in_y;
    logic [POS_Z_W-1:0]  in_z;
    logic [TYPE_W-1:0]   in_type;
    logic [SPAD_W-1:0]   in_pad;
    logic                in_inside;
    logic                in_type_ok;
    logic                in_accept;
    logic [ADDR_W-1:0]   in_addr;

    assign {in_pad, in_type, in_z, in_y, in_x} = s_tdata;
    assign in_inside  = (32'(in_x) < LINE) && (32'(in_y) < LINE) && (32'(in_z) < HEIGHT);
    assign in_type_ok = (32'(in_type) <= SECTIONS);
    assign in_accept  = s_tvalid && s_tready;
    assign in_addr    = ADDR_W'(in_x) + ADDR_W'(in_y) * ADDR_W'(LINE)
                      + ADDR_W'(in_z) * ADDR_W'(LL);

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    logic [1:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [2:0]           step_reg, step_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [POS_XY_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [POS_Z_W-1:0]   z_reg, z_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [NUM_FACES-1:0] vis_reg, vis_next;
    logic [VSIZE_W-1:0]   vsize_reg, vsize_next;
    logic [CNT_W-1:0]     cnt_reg [SECTIONS];
    logic [CNT_W-1:0]     cnt_next [SECTIONS];

    logic                 m_valid_reg, m_valid_next;
    logic [FACE_W-1:0]    m_face_reg, m_face_next;
    logic [SECTION_W-1:0] m_sec_reg, m_sec_next;
    logic [CNT_W-1:0]     m_vtx_reg, m_vtx_next;
    logic [CXY_W-1:0]     m_cx_reg, m_cx_next, m_cy_reg, m_cy_next;
    logic [CZ_W-1:0]      m_cz_reg, m_cz_next;
    logic                 m_last_reg, m_last_next;

    // ------------------------------------------------------------------------
    // voxel memory, single port, registered read
    // ------------------------------------------------------------------------
    logic [TYPE_W-1:0] mem [DEPTH];
    logic [TYPE_W-1:0] mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [TYPE_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    // ------------------------------------------------------------------------
    // chunk boundary handling per face
    // ------------------------------------------------------------------------
    logic [NUM_FACES-1:0] edge_hit;
    logic [NUM_FACES-1:0] edge_vis;

    always_comb begin
        edge_hit[FACE_PZ] = (32'(z_reg) + 1 >= HEIGHT);
        edge_hit[FACE_MZ] = (z_reg == '0);
        edge_hit[FACE_PY] = (32'(y_reg) + 1 >= LINE);
        edge_hit[FACE_MY] = (y_reg == '0);
        edge_hit[FACE_PX] = (32'(x_reg) + 1 >= LINE);
        edge_hit[FACE_MX] = (x_reg == '0);
        // top and bottom are never shown, chunk sides always are
        edge_vis[FACE_PZ] = 1'b0;
        edge_vis[FACE_MZ] = 1'b0;
        edge_vis[FACE_PY] = 1'b1;
        edge_vis[FACE_MY] = 1'b1;
        edge_vis[FACE_PX] = 1'b1;
        edge_vis[FACE_MX] = 1'b1;
    end

    // ------------------------------------------------------------------------
    // face selection for emission
    // ------------------------------------------------------------------------
    logic [FACE_W-1:0]    pick_face;
    logic [NUM_FACES-1:0] pick_rest;
    logic                 type_ok;
    logic [SEC_W-1:0]     sec;
    logic                 emit_load;
    logic                 emit_last;
    logic [PXY_W-1:0]     prod_x, prod_y;
    logic [PZ_W-1:0]      prod_z;

    always_comb begin
        pick_face = FACE_MX;
        // lowest set bit wins: walk from the top down
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (vis_reg[i]) begin
                pick_face = FACE_W'(i);
            end
        end
        pick_rest = vis_reg & ~(NUM_FACES'(1) << pick_face);
    end

    assign type_ok   = (type_reg != '0) && (32'(type_reg) <= SECTIONS);
    assign sec       = SEC_W'(type_reg - TYPE_W'(1));
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign emit_last = (pick_rest == '0);
    assign prod_x    = PXY_W'(x_reg) * PXY_W'(vsize_reg);
    assign prod_y    = PXY_W'(y_reg) * PXY_W'(vsize_reg);
    assign prod_z    = PZ_W'(z_reg) * PZ_W'(vsize_reg);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        step_next  = step_reg;
        addr_next  = addr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        type_next  = type_reg;
        vis_next   = vis_reg;
        vsize_next = cfg_wen ? cfg_wdata : vsize_reg;
        for (int s = 0; s < SECTIONS; s++) begin
            cnt_next[s] = cnt_reg[s];
        end

        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = in_type;

        case (state_reg)
            ST_CLEAR: begin
                // sweep the store to empty after reset
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_addr = in_addr;
                if (in_accept) begin
                    x_next    = in_x;
                    y_next    = in_y;
                    z_next    = in_z;
                    addr_next = in_addr;
                    vis_next  = '0;
                    step_next = '0;
                    case (s_tuser)
                        OP_WRITE: begin
                            mem_we = in_inside && in_type_ok;
                        end
                        OP_START: begin
                            for (int s = 0; s < SECTIONS; s++) begin
                                cnt_next[s] = '0;
                            end
                        end
                        OP_MESH: begin
                            if (in_inside) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // issue read for this step, take the result of the previous one
                case (step_reg)
                    3'd0:    mem_addr = addr_reg;
                    3'd1:    mem_addr = addr_reg + ADDR_W'(LL);
                    3'd2:    mem_addr = addr_reg - ADDR_W'(LL);
                    3'd3:    mem_addr = addr_reg + ADDR_W'(LINE);
                    3'd4:    mem_addr = addr_reg - ADDR_W'(LINE);
                    3'd5:    mem_addr = addr_reg + ADDR_W'(1);
                    3'd6:    mem_addr = addr_reg - ADDR_W'(1);
                    default: mem_addr = addr_reg;
                endcase
                case (step_reg)
                    3'd1: type_next = mem_q;
                    3'd2: vis_next[FACE_PZ] = edge_hit[FACE_PZ] ? edge_vis[FACE_PZ]
                                                                : (mem_q == '0);
                    3'd3: vis_next[FACE_MZ] = edge_hit[FACE_MZ] ? edge_vis[FACE_MZ]
                                                                : (mem_q == '0);
                    3'd4: vis_next[FACE_PY] = edge_hit[FACE_PY] ? edge_vis[FACE_PY]
                                                                : (mem_q == '0);
                    3'd5: vis_next[FACE_MY] = edge_hit[FACE_MY] ? edge_vis[FACE_MY]
                                                                : (mem_q == '0);
                    3'd6: vis_next[FACE_PX] = edge_hit[FACE_PX] ? edge_vis[FACE_PX]
                                                                : (mem_q == '0);
                    3'd7: vis_next[FACE_MX] = edge_hit[FACE_MX] ? edge_vis[FACE_MX]
                                                                : (mem_q == '0);
                    default: begin
                    end
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    // empty voxel or fully enclosed: nothing to emit
                    state_next = (type_ok && vis_next != '0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    vis_next     = pick_rest;
                    cnt_next[sec] = cnt_reg[sec] + CNT_STEP;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_face_next  = m_face_reg;
        m_sec_next   = m_sec_reg;
        m_vtx_next   = m_vtx_reg;
        m_cx_next    = m_cx_reg;
        m_cy_next    = m_cy_reg;
        m_cz_next    = m_cz_reg;
        m_last_next  = m_last_reg;
        if (emit_load) begin
            m_valid_next = 1'b1;
            m_face_next  = pick_face;
            m_sec_next   = SECTION_W'(sec);
            m_vtx_next   = cnt_reg[sec];
            m_cx_next    = prod_x[CXY_W-1:0];
            m_cy_next    = prod_y[CXY_W-1:0];
            m_cz_next    = prod_z[CZ_W-1:0];
            m_last_next  = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            step_reg    <= '0;
            vis_reg     <= '0;
            vsize_reg   <= VSIZE_RESET;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < SECTIONS; s++) begin
                cnt_reg[s] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            step_reg    <= step_next;
            vis_reg     <= vis_next;
            vsize_reg   <= vsize_next;
            m_valid_reg <= m_valid_next;
            for (int s = 0; s < SECTIONS; s++) begin
                cnt_reg[s] <= cnt_next[s];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        type_reg   <= type_next;
        m_face_reg <= m_face_next;
        m_sec_reg  <= m_sec_next;
        m_vtx_reg  <= m_vtx_next;
        m_cx_reg   <= m_cx_next;
        m_cy_reg   <= m_cy_next;
        m_cz_reg   <= m_cz_next;
        m_last_reg <= m_last_next;
    end

    // ------------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_face_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {PAD_W'(0), m_cz_reg, m_cy_reg, m_cx_reg, m_vtx_reg, m_sec_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // the neighbour gather never disturbs the store
    a_read_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !mem_we)
        else $error("voxel store written during neighbour reads");

    // an in-chunk mesh beat always starts the gather
    a_mesh_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser == OP_MESH && in_inside) |=> state_reg == ST_READ)
        else $error("mesh beat did not start neighbour reads");

    // the final face ends emission and shows up flagged as last
    a_last_ends_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_load && emit_last) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("last face did not close the voxel");

    // every emitted face advances its section counter by one quad
    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> cnt_reg[$past(sec)] == $past(cnt_reg[sec]) + CNT_STEP)
        else $error("section counter did not advance by four");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the voxel face culling mesher: writes, mesh passes
// and meshed voxels go in as command beats, and a behavioral copy of the
// chunk and the section counters predicts every face beat, which is checked
// field by field in arrival order; random stalls on both sides and several
// voxel sizes
// ----------------------------------------------------------------------------
module tb;
    import vfcm_pkg::*;

    // the one code that the package leaves unnamed
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CHUNK_CELLS    = LINE_DEF * LINE_DEF * HEIGHT_DEF;
    localparam int MAX_IDLE       = 17;
    localparam int SETTLE_CYCLES  = 30;        // one mesh gather plus six faces, with margin
    localparam int WATCHDOG_LIMIT = 120000;    // reset sweep covers 32768 entries
    localparam int PHASE_ITEMS    = 81;
    localparam int RAND_PHASES    = 5;

    // m_tdata field offsets, lowest field first
    localparam int SEC_LSB = 0;
    localparam int FV_LSB  = SEC_LSB + SECTION_W;
    localparam int CX_LSB  = FV_LSB + CNT_W;
    localparam int CY_LSB  = CX_LSB + CXY_W;
    localparam int CZ_LSB  = CY_LSB + CXY_W;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [POS_XY_W-1:0] x;
        logic [POS_XY_W-1:0] y;
        logic [POS_Z_W-1:0]  z;
        logic [TYPE_W-1:0]   vtype;
        int                  gap;
    } voxel_cmd_t;

    typedef struct {
        logic [FACE_W-1:0]    dir;
        logic [SECTION_W-1:0] section;
        logic [CNT_W-1:0]     first_vertex;
        logic [CXY_W-1:0]     cx;
        logic [CXY_W-1:0]     cy;
        logic [CZ_W-1:0]      cz;
        logic                 last;
    } face_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [VSIZE_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;    // pos_x, pos_y, pos_z, voxel_type
    logic [OP_W-1:0]        s_tuser   = '0;    // operation
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;           // section, first_vertex, center_x,
                                               // center_y, center_z
    logic [FACE_W-1:0]      m_tuser;           // face_dir
    logic                   m_tlast;           // last_face

    voxel_face_culling_mesher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // behavioral copy of the block state
    logic [TYPE_W-1:0]  chunk_types [CHUNK_CELLS];
    logic [CNT_W-1:0]   vertex_cnt  [SECTIONS_DEF];
    logic [VSIZE_W-1:0] voxel_size_now;

    voxel_cmd_t cmd_q[$];      // commands waiting for the driver
    face_t      face_q[$];     // faces predicted but not yet seen
    voxel_cmd_t cmd_on_bus;
    int         gap_cnt  = 0;
    int         stall_cnt = 0;
    bit         s_calm   = 1'b0;
    bit         m_calm   = 1'b0;
    bit         failed   = 1'b0;
    int         quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // face prediction
    // ------------------------------------------------------------------------
    function automatic logic [TYPE_W-1:0] type_at(int x, int y, int z);
        return chunk_types[x + y * LINE_DEF + z * LINE_DEF * LINE_DEF];
    endfunction

    // top and bottom of the chunk hide the face, the x and y borders show it
    function automatic bit face_open(logic [FACE_W-1:0] dir, int x, int y, int z);
        case (dir)
            FACE_PZ: return (z + 1 < HEIGHT_DEF) && (type_at(x, y, z + 1) == 0);
            FACE_MZ: return (z > 0) && (type_at(x, y, z - 1) == 0);
            FACE_PY: return (y + 1 >= LINE_DEF) || (type_at(x, y + 1, z) == 0);
            FACE_MY: return (y == 0) || (type_at(x, y - 1, z) == 0);
            FACE_PX: return (x + 1 >= LINE_DEF) || (type_at(x + 1, y, z) == 0);
            default: return (x == 0) || (type_at(x - 1, y, z) == 0);
        endcase
    endfunction

    task automatic apply_voxel_cmd(voxel_cmd_t c);
        int                    idx;
        int                    total;
        int                    n;
        logic [TYPE_W-1:0]     vt;
        logic [SECTION_W-1:0]  sec;
        logic [FACE_W-1:0]     dir;
        logic [NUM_FACES-1:0]  open_mask;
        face_t                 f;
        idx = c.x + c.y * LINE_DEF + c.z * LINE_DEF * LINE_DEF;
        case (c.op)
            OP_START: begin
                for (int s = 0; s < SECTIONS_DEF; s++) vertex_cnt[s] = '0;
            end
            OP_WRITE: begin
                // types without a section are dropped
                if (c.vtype <= SECTIONS_DEF) chunk_types[idx] = c.vtype;
            end
            OP_MESH: begin
                vt = chunk_types[idx];
                if (vt != 0) begin
                    sec = SECTION_W'(vt - 1);
                    for (int d = 0; d < NUM_FACES; d++) begin
                        dir = FACE_W'(d);
                        open_mask[d] = face_open(dir, c.x, c.y, c.z);
                    end
                    total = $countones(open_mask);
                    n = 0;
                    for (int d = 0; d < NUM_FACES; d++) begin
                        if (open_mask[d]) begin
                            n++;
                            f.dir          = FACE_W'(d);
                            f.section      = sec;
                            f.first_vertex = vertex_cnt[sec];
                            f.cx           = CXY_W'(32'(c.x) * 32'(voxel_size_now));
                            f.cy           = CXY_W'(32'(c.y) * 32'(voxel_size_now));
                            f.cz           = CZ_W'(32'(c.z) * 32'(voxel_size_now));
                            f.last         = (n == total);
                            face_q.push_back(f);
                            vertex_cnt[sec] = vertex_cnt[sec] + CNT_STEP;
                        end
                    end
                end
            end
            default: ;  // unused operation does nothing
        endcase
    endtask

    // ------------------------------------------------------------------------
    // command driver: one beat per queued command, each after its own gap
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_cnt = 0;
        end else begin
            if (s_tvalid && s_tready) apply_voxel_cmd(cmd_on_bus);
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && gap_cnt >= cmd_q[0].gap) begin
                    cmd_on_bus = cmd_q.pop_front();
                    gap_cnt = 0;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cmd_on_bus.op;
                    s_tdata  <= S_TDATA_W'({cmd_on_bus.vtype, cmd_on_bus.z,
                                            cmd_on_bus.y, cmd_on_bus.x});
                end else begin
                    s_tvalid <= 1'b0;
                    if (cmd_q.size() != 0) gap_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // face monitor: random stall after every beat unless m_calm is set, in-order compare
    // ------------------------------------------------------------------------
    task automatic report_field(string name, int unsigned exp, int unsigned act);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        failed = 1'b1;
    endtask

    always @(posedge aclk) begin
        face_t exp;
        face_t act;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                act.dir          = m_tuser;
                act.section      = m_tdata[SEC_LSB +: SECTION_W];
                act.first_vertex = m_tdata[FV_LSB +: CNT_W];
                act.cx           = m_tdata[CX_LSB +: CXY_W];
                act.cy           = m_tdata[CY_LSB +: CXY_W];
                act.cz           = m_tdata[CZ_LSB +: CZ_W];
                act.last         = m_tlast;
                if (face_q.size() == 0) begin
                    $display("%0t: face beat with nothing expected, expected none, actual dir %0d",
                             $time, act.dir);
                    failed = 1'b1;
                end else begin
                    exp = face_q.pop_front();
                    if (exp.dir !== act.dir)
                        report_field("face_dir", 32'(exp.dir), 32'(act.dir));
                    if (exp.section !== act.section)
                        report_field("section", 32'(exp.section), 32'(act.section));
                    if (exp.first_vertex !== act.first_vertex)
                        report_field("first_vertex", 32'(exp.first_vertex),
                                     32'(act.first_vertex));
                    if (exp.cx !== act.cx)
                        report_field("center_x", 32'(exp.cx), 32'(act.cx));
                    if (exp.cy !== act.cy)
                        report_field("center_y", 32'(exp.cy), 32'(act.cy));
                    if (exp.cz !== act.cz)
                        report_field("center_z", 32'(exp.cz), 32'(act.cz));
                    if (exp.last !== act.last)
                        report_field("last_face", 32'(exp.last), 32'(act.last));
                end
                stall_cnt = m_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any beat on either side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d faces outstanding",
                         $time, quiet_cycles, face_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_cmd(logic [OP_W-1:0] op, int x, int y, int z, int vtype);
        voxel_cmd_t c;
        c.op    = op;
        c.x     = POS_XY_W'(x);
        c.y     = POS_XY_W'(y);
        c.z     = POS_Z_W'(z);
        c.vtype = TYPE_W'(vtype);
        c.gap   = s_calm ? 0 : $urandom_range(0, MAX_IDLE);
        cmd_q.push_back(c);
    endtask

    // sender holds off until every face is back and the block has gone quiet
    task automatic wait_idle();
        while (cmd_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (face_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_voxel_size(int unsigned v);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= VSIZE_W'(v);
        voxel_size_now = VSIZE_W'(v);
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int pick_base(int hi);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    initial begin
        int bx;
        int by;
        int bz;
        int r;
        int x;
        int y;
        int z;
        int t;
        int unsigned vs;
        logic [OP_W-1:0] op;

        for (int i = 0; i < CHUNK_CELLS; i++) chunk_types[i] = '0;
        for (int s = 0; s < SECTIONS_DEF; s++) vertex_cnt[s] = '0;
        voxel_size_now = VSIZE_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset voxel size
        queue_cmd(OP_MESH, 0, 0, 0, 0);             // empty voxel
        queue_cmd(OP_WRITE, 0, 0, 0, 1);
        queue_cmd(OP_MESH, 0, 0, 0, 0);             // bottom corner, no -z face
        queue_cmd(OP_WRITE, 15, 15, 127, 4);
        queue_cmd(OP_MESH, 15, 15, 127, 7);         // top corner, no +z face
        queue_cmd(OP_WRITE, 15, 15, 126, 2);
        queue_cmd(OP_MESH, 15, 15, 127, 0);         // -z now covered
        queue_cmd(OP_MESH, 15, 15, 126, 0);
        wait_idle();
        queue_cmd(OP_WRITE, 5, 5, 5, 7);            // type without a section
        queue_cmd(OP_WRITE, 5, 5, 5, 5);
        queue_cmd(OP_MESH, 5, 5, 5, 0);
        queue_cmd(OP_UNUSED, 15, 15, 127, 7);       // unused operation
        queue_cmd(OP_WRITE, 5, 5, 5, 3);
        queue_cmd(OP_MESH, 5, 5, 5, 0);             // isolated, all six faces
        queue_cmd(OP_WRITE, 6, 5, 5, 3);
        queue_cmd(OP_WRITE, 5, 6, 5, 1);
        queue_cmd(OP_MESH, 5, 5, 5, 0);
        queue_cmd(OP_MESH, 6, 5, 5, 0);
        queue_cmd(OP_START, 0, 0, 0, 0);
        queue_cmd(OP_MESH, 5, 5, 5, 0);             // counters start over
        queue_cmd(OP_WRITE, 5, 5, 5, 0);
        queue_cmd(OP_MESH, 5, 5, 5, 0);             // cleared again
        queue_cmd(OP_MESH, 5, 6, 5, 0);
        wait_idle();

        // random phases, each at its own voxel size and idling mix
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       vs = 1;
                1:       vs = 1024;
                2:       vs = 2047;                 // centres wrap
                3:       vs = $urandom_range(1, 1024);
                default: vs = $urandom_range(1, 2047);
            endcase
            write_voxel_size(vs);
            s_calm = (p == 2);
            m_calm = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // a small cluster so that meshes see filled neighbours
                if (i % 30 == 0) begin
                    bx = pick_base(LINE_DEF - 4);
                    by = pick_base(LINE_DEF - 4);
                    bz = pick_base(HEIGHT_DEF - 4);
                end
                if ($urandom_range(0, 4) == 0) begin
                    x = $urandom_range(0, LINE_DEF - 1);
                    y = $urandom_range(0, LINE_DEF - 1);
                    z = $urandom_range(0, HEIGHT_DEF - 1);
                end else begin
                    x = bx + $urandom_range(0, 3);
                    y = by + $urandom_range(0, 3);
                    z = bz + $urandom_range(0, 3);
                end
                r = $urandom_range(0, 99);
                if (r < 40) op = OP_WRITE;
                else if (r < 45) op = OP_START;
                else if (r < 49) op = OP_UNUSED;
                else op = OP_MESH;
                if (op == OP_WRITE && $urandom_range(0, 9) != 0)
                    t = $urandom_range(0, SECTIONS_DEF);
                else
                    t = $urandom_range(0, 7);
                queue_cmd(op, x, y, z, t);
            end
            wait_idle();
        end
        s_calm = 1'b0;
        m_calm = 1'b0;

        if (!failed && face_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
